// ===== rtl/jhmp_pkg.sv =====
package jhmp_pkg;

	typedef enum logic [3:0] {
		K_HEIGHT,
		K_WIDTH,
		K_COUNT,
		K_ID,
		K_SAMP,
		K_QSEL,
		K_QUANT,
		K_HCOUNT,
		K_HSYM,
		K_HTOTAL,
		K_RESTART,
		K_SCANSEL,
		K_SCANSTART,
		K_EOI,
		K_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		PH_SOI0,
		PH_SOI1,
		PH_MARK,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_SKIP,
		PH_SOS,
		PH_SOF,
		PH_DRI,
		PH_DQT_HEAD,
		PH_DQT_DATA,
		PH_DHT_HEAD,
		PH_DHT_BITS,
		PH_DHT_SYMS
	} phase_t;

	localparam logic [7:0] M_FILL = 8'hff;
	localparam logic [7:0] M_SOI  = 8'hd8;
	localparam logic [7:0] M_EOI  = 8'hd9;
	localparam logic [7:0] M_SOS  = 8'hda;
	localparam logic [7:0] M_SOF0 = 8'hc0;
	localparam logic [7:0] M_DQT  = 8'hdb;
	localparam logic [7:0] M_DHT  = 8'hc4;
	localparam logic [7:0] M_DRI  = 8'hdd;
	localparam logic [7:0] M_RST0 = 8'hd0;
	localparam logic [7:0] M_RST7 = 8'hd7;
	localparam logic [7:0] M_TEM  = 8'h01;

	localparam int unsigned RES_MAX = 4;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  slot;
		logic [7:0]  index;
		logic [23:0] value;
	} res_t;

	typedef struct packed {
		logic [2:0]              cnt;
		res_t [RES_MAX-1:0]      ent;
	} bundle_t;

endpackage

// ===== rtl/jhmp_if.sv =====
interface jhmp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface jhmp_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [1:0]  slot;
	logic [7:0]  index;
	logic [23:0] value;
	logic        last_of_run;
	modport source(output valid, output kind, output slot, output index, output value,
		output last_of_run, input ready);
	modport sink(input valid, input kind, input slot, input index, input value,
		input last_of_run, output ready);
endinterface

interface jhmp_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] stream_length;
	modport source(output valid, output stream_length, input ready);
	modport sink(input valid, input stream_length, output ready);
endinterface

// ===== rtl/jhmp_front.sv =====
module jhmp_front #(
	parameter int MAX_COMPONENTS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	jhmp_byte_if.sink         data,
	jhmp_cfg_if.sink          cfg,
	output logic              push,
	output jhmp_pkg::bundle_t push_bundle,
	input  logic              q_ready
);
	import jhmp_pkg::*;

	localparam int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam logic [2:0] MAXC = 3'(MAX_COMPONENTS);

	logic [23:0] len_q;
	phase_t      phase_q, phase_n;
	logic [23:0] pos_q;
	logic [15:0] seg_rem_q, seg_rem_n;
	logic [11:0] fc_q, fc_n;
	logic [11:0] htot_q, htot_n;
	logic [3:0]  table_q, table_n;
	logic [7:0]  ids_q [MAX_COMPONENTS];
	logic [7:0]  ids_n [MAX_COMPONENTS];
	logic [7:0]  scnt_q, scnt_n;
	logic [7:0]  sid_q, sid_n;
	logic        done_q, done_n;
	logic [7:0]  marker_q, marker_n;
	logic [7:0]  hold_q, hold_n;
	logic [7:0]  fcount_q, fcount_n;
	logic        run128_q, run128_n;
	logic        temit_q, temit_n;
	logic [1:0]  sof_sub_q, sof_sub_n;
	logic [2:0]  sof_idx_q, sof_idx_n;

	logic [7:0]  b;
	logic        accept;
	logic [2:0]  n;
	res_t [RES_MAX-1:0] ent;
	logic        fail, sstart, em;
	logic [15:0] rem, seglen, payload;
	logic [11:0] fc_inc, k;
	logic [10:0] ci;
	logic [2:0]  lim, flim;
	logic [25:0] pos26, len26;
	logic [9:0]  tb;
	logic [7:0]  run;

	function automatic res_t mk(kind_t kd, logic [1:0] s, logic [7:0] i, logic [23:0] v);
		res_t r;
		r.kind  = kd;
		r.slot  = s;
		r.index = i;
		r.value = v;
		return r;
	endfunction

	function automatic logic [2:0] inc(logic [2:0] x);
		return (x == 3'd4) ? x : x + 3'd1;
	endfunction

	assign b        = data.data_byte;
	assign data.ready = q_ready;
	assign cfg.ready  = 1'b1;
	assign accept   = data.valid && q_ready;
	assign pos26    = {2'b00, pos_q};
	assign len26    = {2'b00, len_q};

	always_comb begin
		phase_n   = phase_q;
		seg_rem_n = seg_rem_q;
		fc_n      = fc_q;
		htot_n    = htot_q;
		table_n   = table_q;
		ids_n     = ids_q;
		scnt_n    = scnt_q;
		sid_n     = sid_q;
		done_n    = done_q;
		marker_n  = marker_q;
		hold_n    = hold_q;
		fcount_n  = fcount_q;
		run128_n  = run128_q;
		temit_n   = temit_q;
		sof_sub_n = sof_sub_q;
		sof_idx_n = sof_idx_q;
		n         = '0;
		ent       = '0;
		fail      = 1'b0;
		sstart    = 1'b0;
		em        = 1'b0;
		rem       = (seg_rem_q != 16'd0) ? seg_rem_q - 16'd1 : 16'd0;
		fc_inc    = (fc_q < 12'd4095) ? fc_q + 12'd1 : fc_q;
		seglen    = {hold_q, b};
		payload   = seglen - 16'd2;
		k         = fc_q - 12'd1;
		ci        = k[11:1];
		lim       = (scnt_q < 8'(MAXC)) ? scnt_q[2:0] : MAXC;
		flim      = (fcount_q < 8'(MAXC)) ? fcount_q[2:0] : MAXC;
		tb        = {1'b0, b, 1'b0} + {2'b00, b};
		run       = (b[7:4] != 4'd0) ? 8'd128 : 8'd64;

		unique case (phase_q)
			PH_SOI0: begin
				if (len_q < 24'd4 || b != M_FILL) fail = 1'b1;
				else phase_n = PH_SOI1;
			end
			PH_SOI1: begin
				if (b != M_SOI) fail = 1'b1;
				else em = 1'b1;
			end
			PH_MARK: begin
				if (b == M_FILL) begin
					if (pos26 + 26'd1 >= len26) fail = 1'b1;
				end else if (b == M_EOI) begin
					ent[0] = mk(K_EOI, 2'd0, 8'd0, 24'd0);
					n      = 3'd1;
					done_n = 1'b1;
				end else if (b == M_TEM || (b >= M_RST0 && b <= M_RST7)) begin
					em = 1'b1;
				end else if (pos26 + 26'd3 > len26) begin
					fail = 1'b1;
				end else begin
					marker_n = b;
					phase_n  = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				hold_n  = b;
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (seglen < 16'd2 || pos26 - 26'd1 + {10'd0, seglen} > len26) begin
					fail = 1'b1;
				end else begin
					seg_rem_n = payload;
					fc_n      = '0;
					if (marker_q == M_SOS) begin
						if (payload == 16'd0) begin
							scnt_n = '0;
							ent[0] = mk(K_COUNT, 2'd0, 8'd0, 24'd0);
							n      = 3'd1;
							fail   = 1'b1;
						end else begin
							phase_n = PH_SOS;
						end
					end else begin
						unique case (marker_q)
							M_SOF0:  phase_n = (payload >= 16'd6) ? PH_SOF : PH_SKIP;
							M_DQT:   phase_n = PH_DQT_HEAD;
							M_DHT:   phase_n = (payload >= 16'd17) ? PH_DHT_HEAD : PH_SKIP;
							M_DRI:   phase_n = (payload >= 16'd2) ? PH_DRI : PH_SKIP;
							default: phase_n = PH_SKIP;
						endcase
						if (payload == 16'd0) em = 1'b1;
					end
				end
			end
			default: begin
				fc_n = fc_inc;
				unique case (phase_q)
					PH_SOS: begin
						if (fc_q == 12'd0) begin
							scnt_n = b;
							ent[0] = mk(K_COUNT, 2'd0, 8'd0, {16'd0, b});
							n      = 3'd1;
							if ({1'b0, rem} + 17'd1 < {8'd0, b, 1'b0} + 17'd4) fail = 1'b1;
						end else if (ci < {8'd0, lim}) begin
							if (!k[0]) begin
								sid_n = b;
							end else begin
								for (int c = 0; c < MAX_COMPONENTS; c++) begin
									if (3'(c) < lim && ids_q[c] == sid_q) begin
										ent[n[1:0]] = mk(K_SCANSEL, 2'(c), ci[7:0], {16'd0, b});
										n = inc(n);
									end
								end
							end
						end
					end
					PH_SOF: begin
						if (fc_q == 12'd1 || fc_q == 12'd3) begin
							hold_n = b;
						end else if (fc_q == 12'd2) begin
							ent[0] = mk(K_HEIGHT, 2'd0, 8'd0, {8'd0, hold_q, b});
							n      = 3'd1;
						end else if (fc_q == 12'd4) begin
							ent[0] = mk(K_WIDTH, 2'd0, 8'd0, {8'd0, hold_q, b});
							n      = 3'd1;
						end else if (fc_q == 12'd5) begin
							fcount_n  = b;
							sof_sub_n = '0;
							sof_idx_n = '0;
							ent[0]    = mk(K_COUNT, 2'd0, 8'd0, {16'd0, b});
							n         = 3'd1;
							if (rem < {6'd0, tb}) fail = 1'b1;
						end else if (fc_q >= 12'd6) begin
							if (sof_idx_q < flim) begin
								case (sof_sub_q)
									2'd0: begin
										ids_n[sof_idx_q[IW-1:0]] = b;
										ent[0] = mk(K_ID, sof_idx_q[1:0], {5'd0, sof_idx_q},
											{16'd0, b});
									end
									2'd1: ent[0] = mk(K_SAMP, sof_idx_q[1:0], {5'd0, sof_idx_q},
										{16'd0, b});
									default: ent[0] = mk(K_QSEL, sof_idx_q[1:0],
										{5'd0, sof_idx_q}, {16'd0, b});
								endcase
								n = 3'd1;
							end
							if (sof_sub_q == 2'd2) begin
								sof_sub_n = '0;
								sof_idx_n = (sof_idx_q < 3'd4) ? sof_idx_q + 3'd1 : sof_idx_q;
							end else begin
								sof_sub_n = sof_sub_q + 2'd1;
							end
						end
					end
					PH_DRI: begin
						if (fc_q == 12'd0) begin
							hold_n = b;
						end else if (fc_q == 12'd1) begin
							ent[0] = mk(K_RESTART, 2'd0, 8'd0, {8'd0, hold_q, b});
							n      = 3'd1;
						end
					end
					PH_DQT_HEAD: begin
						run128_n = (b[7:4] != 4'd0);
						if ({8'd0, run} > rem) begin
							fail = 1'b1;
						end else begin
							table_n = b[3:0];
							temit_n = (b[3:0] < 4'd4) && (b[7:4] == 4'd0);
							fc_n    = '0;
							phase_n = PH_DQT_DATA;
						end
					end
					PH_DQT_DATA: begin
						if (temit_q) begin
							ent[0] = mk(K_QUANT, table_q[1:0], fc_q[7:0], {16'd0, b});
							n      = 3'd1;
						end
						if (fc_inc >= (run128_q ? 12'd128 : 12'd64)) phase_n = PH_DQT_HEAD;
					end
					PH_DHT_HEAD: begin
						temit_n = (b[3:0] < 4'd4);
						table_n = {2'b00, b[0], b[4]};
						htot_n  = '0;
						fc_n    = '0;
						phase_n = PH_DHT_BITS;
					end
					PH_DHT_BITS: begin
						htot_n = htot_q + {4'd0, b};
						if (temit_q) begin
							ent[0] = mk(K_HCOUNT, table_q[1:0], fc_q[7:0], {16'd0, b});
							n      = 3'd1;
						end
						if (fc_inc >= 12'd16) begin
							if (temit_q) begin
								ent[n[1:0]] = mk(K_HTOTAL, table_q[1:0], 8'd0, {12'd0, htot_n});
								n = inc(n);
							end
							if ({4'd0, htot_n} > rem) begin
								fail = 1'b1;
							end else begin
								fc_n = '0;
								if (htot_n != 12'd0) phase_n = PH_DHT_SYMS;
								else phase_n = (rem >= 16'd17) ? PH_DHT_HEAD : PH_SKIP;
							end
						end
					end
					PH_DHT_SYMS: begin
						if (temit_q && fc_q[11:8] == 4'd0) begin
							ent[0] = mk(K_HSYM, table_q[1:0], fc_q[7:0], {16'd0, b});
							n      = 3'd1;
						end
						if (fc_inc >= htot_q) phase_n = (rem >= 16'd17) ? PH_DHT_HEAD : PH_SKIP;
					end
					default: ;
				endcase
				seg_rem_n = rem;
				if (!fail && rem == 16'd0) begin
					if (marker_q == M_SOS) sstart = 1'b1;
					else em = 1'b1;
				end
			end
		endcase

		if (em) begin
			phase_n = PH_MARK;
			if (pos26 + 26'd5 > len26) fail = 1'b1;
		end
		if (sstart) begin
			if (n != 3'd4) ent[n[1:0]] = mk(K_SCANSTART, 2'd0, 8'd0, pos_q + 24'd1);
			n      = inc(n);
			done_n = 1'b1;
		end
		if (fail) begin
			if (n != 3'd4) ent[n[1:0]] = mk(K_ERROR, 2'd0, 8'd0, 24'd0);
			n      = inc(n);
			done_n = 1'b1;
		end
	end

	assign push            = accept && !done_q && (n != 3'd0);
	assign push_bundle.cnt = n;
	assign push_bundle.ent = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			phase_q   <= PH_SOI0;
			pos_q     <= '0;
			seg_rem_q <= '0;
			fc_q      <= '0;
			htot_q    <= '0;
			table_q   <= '0;
			for (int c = 0; c < MAX_COMPONENTS; c++) ids_q[c] <= '0;
			scnt_q    <= '0;
			sid_q     <= '0;
			done_q    <= 1'b0;
			marker_q  <= '0;
			hold_q    <= '0;
			fcount_q  <= '0;
			run128_q  <= 1'b0;
			temit_q   <= 1'b0;
			sof_sub_q <= '0;
			sof_idx_q <= '0;
		end else begin
			if (cfg.valid) len_q <= cfg.stream_length;
			if (accept && !done_q) begin
				phase_q   <= phase_n;
				pos_q     <= pos_q + 24'd1;
				seg_rem_q <= seg_rem_n;
				fc_q      <= fc_n;
				htot_q    <= htot_n;
				table_q   <= table_n;
				ids_q     <= ids_n;
				scnt_q    <= scnt_n;
				sid_q     <= sid_n;
				done_q    <= done_n;
				marker_q  <= marker_n;
				hold_q    <= hold_n;
				fcount_q  <= fcount_n;
				run128_q  <= run128_n;
				temit_q   <= temit_n;
				sof_sub_q <= sof_sub_n;
				sof_idx_q <= sof_idx_n;
			end
		end
	end

endmodule

// ===== rtl/jhmp_fifo.sv =====
module jhmp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jhmp_pkg::bundle_t push_bundle,
	output logic              in_ready,
	input  logic              pop,
	output logic              out_valid,
	output jhmp_pkg::bundle_t out_bundle
);
	import jhmp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	bundle_t         mem_q [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [AW:0]     cnt_q;
	logic            do_push, do_pop;

	assign in_ready   = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid  = (cnt_q != '0);
	assign out_bundle = mem_q[rptr_q];
	assign do_push    = push && in_ready;
	assign do_pop     = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + AW'(1);
			if (do_pop) rptr_q <= rptr_q + AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

// ===== rtl/jhmp_back.sv =====
module jhmp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  jhmp_pkg::bundle_t q_bundle,
	output logic              pop,
	jhmp_res_if.source        result
);
	import jhmp_pkg::*;

	logic       cur_valid_q;
	bundle_t    cur_q;
	logic [1:0] idx_q;
	res_t       r;
	logic       last, adv;

	assign r    = cur_q.ent[idx_q];
	assign last = ({1'b0, idx_q} + 3'd1 == cur_q.cnt);
	assign adv  = !cur_valid_q || (result.ready && last);
	assign pop  = adv && q_valid;

	assign result.valid       = cur_valid_q;
	assign result.kind        = r.kind;
	assign result.slot        = r.slot;
	assign result.index       = r.index;
	assign result.value       = r.value;
	assign result.last_of_run = last;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (adv) begin
			cur_valid_q <= q_valid;
			idx_q       <= '0;
		end else if (result.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/jpeg_header_marker_parser_top.sv =====
// Streaming JPEG baseline header parser. It takes one stream byte per clock and
// stalls only when its four-entry result queue is full; a byte that gives k results
// sends them one result per cycle while result ready is high, the last flagged by
// last_of_run. A result is registered in the queue and then in an output register.
// The user writes the stream_length register only while idle, which the parser does
// not enforce. After a scan start, end of image or error, bytes are ignored until reset.
module jpeg_header_marker_parser_top #(
	parameter int MAX_COMPONENTS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	jhmp_byte_if.sink  data,
	jhmp_cfg_if.sink   cfg,
	jhmp_res_if.source result
);
	import jhmp_pkg::*;

	logic    push, q_in_ready, q_valid, pop;
	bundle_t push_bundle, q_bundle;

	jhmp_front #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data       (data),
		.cfg        (cfg),
		.push       (push),
		.push_bundle(push_bundle),
		.q_ready    (q_in_ready)
	);

	jhmp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_bundle(push_bundle),
		.in_ready   (q_in_ready),
		.pop        (pop),
		.out_valid  (q_valid),
		.out_bundle (q_bundle)
	);

	jhmp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_bundle(q_bundle),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== rtl/jhmp_checker.sv =====
module jhmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  kind,
	input logic [1:0]  slot,
	input logic [7:0]  index,
	input logic [23:0] value,
	input logic        last
);
	import jhmp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value))
		else $error("result changed while stalled");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_EOI || kind == K_ERROR || kind == K_SCANSTART) |-> last)
		else $error("terminal result not last of its byte");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_EOI || kind == K_ERROR) |->
		value == 24'd0 && slot == 2'd0 && index == 8'd0)
		else $error("end or error result carries data");

	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_HEIGHT || kind == K_WIDTH || kind == K_RESTART) |->
		slot == 2'd0 && index == 8'd0 && value[23:16] == 8'd0)
		else $error("frame field out of form");

endmodule

bind jpeg_header_marker_parser_top jhmp_checker u_jhmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.kind     (result.kind),
	.slot     (result.slot),
	.index    (result.index),
	.value    (result.value),
	.last     (result.last_of_run)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import jhmp_pkg::*;

	class jpeg_hdr_scoreboard;
		typedef struct {
			res_t r;
			bit   last;
		} expect_t;

		expect_t     pending_q[$];
		res_t        step_q[$];
		int unsigned errors;
		int unsigned checked;

		int unsigned strm_len;
		phase_t      phase;
		int unsigned pos;
		int unsigned seg_rem;
		int unsigned fcnt;
		int unsigned hsum;
		int unsigned tbl;
		int unsigned ids [4];
		int unsigned scan_cnt;
		int unsigned scan_id;
		bit          done;
		int unsigned marker;
		int unsigned hold;
		int unsigned frame_cnt;
		int unsigned run_len;
		bit          tbl_emit;

		function new();
			strm_len = 0;
			phase = PH_SOI0;
			pos = 0;
			seg_rem = 0;
			fcnt = 0;
			hsum = 0;
			tbl = 0;
			foreach (ids[c]) ids[c] = 0;
			scan_cnt = 0;
			scan_id = 0;
			done = 0;
			marker = 0;
			hold = 0;
			frame_cnt = 0;
			run_len = 0;
			tbl_emit = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_length(logic [23:0] v);
			strm_len = v;
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction

		function void put_res(kind_t k, int unsigned s, int unsigned i, int unsigned v);
			if (step_q.size() < RES_MAX)
				step_q.push_back(res_t'{k, s[1:0], i[7:0], v[23:0]});
		endfunction

		function void stop_err();
			put_res(K_ERROR, 0, 0, 0);
			done = 1;
		endfunction

		function int unsigned ncomp(int unsigned n);
			return n < 4 ? n : 4;
		endfunction

		function void to_marker(int unsigned nxt);
			phase = PH_MARK;
			if (nxt + 4 > strm_len)
				stop_err();
		endfunction

		function phase_t huff_next(int unsigned r);
			return r >= 17 ? PH_DHT_HEAD : PH_SKIP;
		endfunction

		function void open_segment(int unsigned pl, int unsigned nxt);
			seg_rem = pl;
			fcnt = 0;
			case (marker)
				M_SOS: begin
					if (pl == 0) begin
						scan_cnt = 0;
						put_res(K_COUNT, 0, 0, 0);
						stop_err();
					end else
						phase = PH_SOS;
					return;
				end
				M_SOF0: phase = pl >= 6 ? PH_SOF : PH_SKIP;
				M_DQT: phase = PH_DQT_HEAD;
				M_DHT: phase = huff_next(pl);
				M_DRI: phase = pl >= 2 ? PH_DRI : PH_SKIP;
				default: phase = PH_SKIP;
			endcase
			if (pl == 0)
				to_marker(nxt);
		endfunction

		function void segment_byte(int unsigned b, int unsigned r);
			int unsigned off, lim, i, k;
			off = fcnt;
			if (fcnt < 4095)
				fcnt++;
			case (phase)
				PH_SOS: begin
					if (off == 0) begin
						scan_cnt = b;
						put_res(K_COUNT, 0, 0, b);
						if (r + 1 < 2 * b + 4)
							stop_err();
					end else begin
						k = off - 1;
						i = k >> 1;
						lim = ncomp(scan_cnt);
						if (i < lim) begin
							if (k[0] == 0)
								scan_id = b;
							else
								for (int c = 0; c < lim; c++)
									if (ids[c] == scan_id)
										put_res(K_SCANSEL, c, i, b);
						end
					end
				end
				PH_SOF: begin
					if (off == 1 || off == 3)
						hold = b;
					else if (off == 2)
						put_res(K_HEIGHT, 0, 0, (hold << 8) | b);
					else if (off == 4)
						put_res(K_WIDTH, 0, 0, (hold << 8) | b);
					else if (off == 5) begin
						frame_cnt = b;
						put_res(K_COUNT, 0, 0, b);
						if (r < 3 * b)
							stop_err();
					end else if (off >= 6) begin
						k = off - 6;
						i = k / 3;
						if (i < ncomp(frame_cnt)) begin
							case (k % 3)
								0: begin
									ids[i] = b;
									put_res(K_ID, i, i, b);
								end
								1: put_res(K_SAMP, i, i, b);
								default: put_res(K_QSEL, i, i, b);
							endcase
						end
					end
				end
				PH_DRI: begin
					if (off == 0)
						hold = b;
					else if (off == 1)
						put_res(K_RESTART, 0, 0, (hold << 8) | b);
				end
				PH_DQT_HEAD: begin
					run_len = (b >> 4) != 0 ? 128 : 64;
					if (run_len > r)
						stop_err();
					else begin
						tbl = b & 15;
						tbl_emit = tbl < 4 && (b >> 4) == 0;
						fcnt = 0;
						phase = PH_DQT_DATA;
					end
				end
				PH_DQT_DATA: begin
					if (tbl_emit)
						put_res(K_QUANT, tbl, off, b);
					if (fcnt >= run_len)
						phase = PH_DQT_HEAD;
				end
				PH_DHT_HEAD: begin
					tbl_emit = (b & 15) < 4;
					tbl = ((b >> 4) & 1) | ((b << 1) & 2);
					hsum = 0;
					fcnt = 0;
					phase = PH_DHT_BITS;
				end
				PH_DHT_BITS: begin
					hsum = (hsum + b) & 12'hfff;
					if (tbl_emit)
						put_res(K_HCOUNT, tbl, off, b);
					if (fcnt >= 16) begin
						if (tbl_emit)
							put_res(K_HTOTAL, tbl, 0, hsum);
						if (hsum > r)
							stop_err();
						else begin
							fcnt = 0;
							phase = hsum != 0 ? PH_DHT_SYMS : huff_next(r);
						end
					end
				end
				PH_DHT_SYMS: begin
					if (tbl_emit && off < 256)
						put_res(K_HSYM, tbl, off, b);
					if (fcnt >= hsum)
						phase = huff_next(r);
				end
				default: ;
			endcase
		endfunction

		function void note(logic [7:0] db);
			int unsigned b, p, r, seglen;
			b = db;
			p = pos;
			step_q.delete();
			if (done)
				return;
			case (phase)
				PH_SOI0: begin
					if (strm_len < 4 || b != M_FILL)
						stop_err();
					else
						phase = PH_SOI1;
				end
				PH_SOI1: begin
					if (b != M_SOI)
						stop_err();
					else
						to_marker(p + 1);
				end
				PH_MARK: begin
					if (b == M_FILL) begin
						if (p + 1 >= strm_len)
							stop_err();
					end else if (b == M_EOI) begin
						put_res(K_EOI, 0, 0, 0);
						done = 1;
					end else if (b == M_TEM || (b >= M_RST0 && b <= M_RST7))
						to_marker(p + 1);
					else if (p + 3 > strm_len)
						stop_err();
					else begin
						marker = b;
						phase = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					hold = b;
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					seglen = (hold << 8) | b;
					if (seglen < 2 || (p - 1) + seglen > strm_len)
						stop_err();
					else
						open_segment(seglen - 2, p + 1);
				end
				default: begin
					r = seg_rem != 0 ? seg_rem - 1 : 0;
					segment_byte(b, r);
					seg_rem = r;
					if (!done && r == 0) begin
						if (marker == M_SOS) begin
							put_res(K_SCANSTART, 0, 0, p + 1);
							done = 1;
						end else
							to_marker(p + 1);
					end
				end
			endcase
			pos = (p + 1) & 24'hffffff;
			foreach (step_q[n])
				pending_q.push_back(expect_t'{step_q[n], n == step_q.size() - 1});
		endfunction

		task report(string what);
			$display("[%0t] result %0d: %s", $realtime, checked, what);
			errors++;
		endtask

		task check(logic [3:0] k, logic [1:0] s, logic [7:0] i, logic [23:0] v, logic l);
			expect_t e;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d value %0h", k, v));
			end else begin
				e = pending_q.pop_front();
				if (k !== e.r.kind)
					report($sformatf("kind %0d, want %0d", k, e.r.kind));
				if (s !== e.r.slot)
					report($sformatf("slot %0d, want %0d", s, e.r.slot));
				if (i !== e.r.index)
					report($sformatf("index %0d, want %0d", i, e.r.index));
				if (v !== e.r.value)
					report($sformatf("value %0h, want %0h", v, e.r.value));
				if (l !== e.last)
					report($sformatf("last_of_run %0b, want %0b", l, e.last));
			end
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;

	jhmp_byte_if byte_bus();
	jhmp_cfg_if  cfg_bus();
	jhmp_res_if  res_bus();

	jpeg_header_marker_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.data(byte_bus),
		.cfg(cfg_bus),
		.result(res_bus)
	);

	jpeg_hdr_scoreboard hdr_sb = new();

	logic [7:0]  jpeg_bytes[$];
	logic [7:0]  seg_body[$];
	int          cut_at[$];
	int          cut_len[$];
	int unsigned frame_ids [4];
	int unsigned results_seen;
	bit          send_quiet;
	bit          recv_quiet;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (byte_bus.valid && byte_bus.ready)
			hdr_sb.note(byte_bus.data_byte);
		if (cfg_bus.valid && cfg_bus.ready)
			hdr_sb.set_length(cfg_bus.stream_length);
		if (res_bus.valid && res_bus.ready)
			hdr_sb.check(res_bus.kind, res_bus.slot, res_bus.index, res_bus.value,
				res_bus.last_of_run);
	end

	function void put(int unsigned b);
		jpeg_bytes.push_back(b[7:0]);
	endfunction

	function void add_seg(int unsigned m, bit with_ff);
		int unsigned n;
		n = seg_body.size() + 2;
		if (with_ff)
			put(M_FILL);
		put(m);
		put(n >> 8);
		put(n);
		foreach (seg_body[j]) jpeg_bytes.push_back(seg_body[j]);
		seg_body.delete();
	endfunction

	function void body(int unsigned b);
		seg_body.push_back(b[7:0]);
	endfunction

	function void make_sof(int unsigned n, bit with_ff);
		int unsigned id;
		body(8);
		repeat (4) body($urandom_range(0, 255));
		body(n);
		for (int c = 0; c < n; c++) begin
			id = $urandom_range(0, 5);
			if (c < 4)
				frame_ids[c] = id;
			body(id);
			body($urandom_range(0, 255));
			body($urandom_range(0, 255));
		end
		add_seg(M_SOF0, with_ff);
	endfunction

	function void make_dqt(int unsigned head);
		body(head);
		repeat ((head >> 4) != 0 ? 128 : 64) body($urandom_range(0, 255));
		add_seg(M_DQT, 1);
	endfunction

	function void make_dht(int unsigned ntab, bit tail);
		int unsigned cnt [16];
		int unsigned sum;
		repeat (ntab) begin
			sum = 0;
			body(($urandom_range(0, 1) << 4) | $urandom_range(0, 5));
			foreach (cnt[j]) begin
				cnt[j] = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
				sum += cnt[j];
				body(cnt[j]);
			end
			repeat (sum) body($urandom_range(0, 255));
		end
		if (tail)
			repeat ($urandom_range(1, 16)) body($urandom_range(0, 255));
		add_seg(M_DHT, 1);
	endfunction

	function void make_sos(int unsigned n, int unsigned extra);
		body(n);
		for (int c = 0; c < n; c++) begin
			body($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
				frame_ids[$urandom_range(0, 3)]);
			body($urandom_range(0, 255));
		end
		repeat (extra) body($urandom_range(0, 255));
		add_seg(M_SOS, 1);
	endfunction

	function void build_stream();
		bit big_done;
		int last_cut;
		big_done = 0;
		put(M_FILL);
		put(M_SOI);
		put(M_FILL);
		put(M_FILL);
		put(M_FILL);
		put(M_TEM);
		put(M_FILL);
		put(M_RST0);
		put(M_FILL);
		put(M_RST7);
		make_sof(3, 1);
		repeat (5) body(8'hff);
		add_seg(M_SOF0, 1);
		body(8'hff);
		body(8'hff);
		add_seg(M_DRI, 1);
		add_seg(M_DRI, 1);
		body(0);
		body(0);
		add_seg(M_DRI, 0);
		add_seg(8'he0, 1);
		make_dht(1, 1);
		make_dqt(8'h00);
		cut_at.push_back(jpeg_bytes.size());
		cut_len.push_back($urandom_range(24'h010000, 24'hfffffe));
		last_cut = jpeg_bytes.size();
		while (jpeg_bytes.size() < 440) begin
			case ($urandom_range(0, 8))
				0: make_sof($urandom_range(0, 9) == 0 ? 5 : $urandom_range(1, 4),
					$urandom_range(0, 3) != 0);
				1, 2: make_dqt($urandom_range(0, 5) == 0 ? 8'h10 | $urandom_range(0, 15) :
					$urandom_range(0, 5));
				3, 4: make_dht($urandom_range(1, 2), $urandom_range(0, 1));
				5: begin
					body($urandom_range(0, 255));
					body($urandom_range(0, 255));
					add_seg(M_DRI, 1);
				end
				6: begin
					repeat ($urandom_range(0, 6)) body($urandom_range(0, 255));
					add_seg($urandom_range(8'he0, 8'hfe), 1);
				end
				7: begin
					repeat ($urandom_range(1, 3)) put(M_FILL);
					put($urandom_range(0, 1) != 0 ? M_TEM : $urandom_range(M_RST0, M_RST7));
				end
				default: begin
					if (!big_done) begin
						big_done = 1;
						body(8'h00);
						repeat (14) body(0);
						body(5);
						body(255);
						repeat (260) body($urandom_range(0, 255));
						add_seg(M_DHT, 1);
					end
				end
			endcase
			if (jpeg_bytes.size() - last_cut > 150) begin
				last_cut = jpeg_bytes.size();
				cut_at.push_back(last_cut);
				cut_len.push_back($urandom_range(24'h001000, 24'hffffff));
			end
		end
		cut_at.push_back(jpeg_bytes.size());
		case ($urandom_range(0, 5))
			0: begin
				put(M_FILL);
				put(M_EOI);
			end
			1: make_sos($urandom_range(1, 4), 3);
			2: make_sos(3, 1);
			3: begin
				put(M_FILL);
				put(8'he1);
				put(0);
				put(1);
			end
			4: begin
				repeat (8) body($urandom_range(0, 255));
				seg_body[0] = 8'h00;
				add_seg(M_DQT, 1);
			end
			default: add_seg(M_SOS, 1);
		endcase
		cut_len.push_back(jpeg_bytes.size() + $urandom_range(0, 2));
		repeat (12) put($urandom_range(0, 255));
	endfunction

	task send_byte(logic [7:0] b);
		int unsigned k;
		k = send_quiet ? 0 : $urandom_range(0, 7);
		if (k > 0) begin
			byte_bus.valid <= 1'b0;
			repeat (k) @(negedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		@(posedge clk);
		while (!byte_bus.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task write_length(logic [23:0] v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.stream_length <= v;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task drain();
		byte_bus.valid <= 1'b0;
		while (hdr_sb.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.stream_length = '0;
		res_bus.ready = 1'b0;
		send_quiet = 0;
		build_stream();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_length(24'h000000);
		write_length(24'h000003);
		write_length(24'hffffff);
		for (int j = 0; j < jpeg_bytes.size(); j++) begin
			if (cut_at.size() != 0 && cut_at[0] == j) begin
				void'(cut_at.pop_front());
				drain();
				write_length(24'(cut_len.pop_front()));
			end
			if (j % 40 == 0)
				send_quiet = $urandom_range(0, 3) == 0;
			send_byte(jpeg_bytes[j]);
		end
		byte_bus.valid <= 1'b0;
		while (hdr_sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (hdr_sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned k;
		recv_quiet = 0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen % 30 == 0)
				recv_quiet = $urandom_range(0, 3) == 0;
			k = recv_quiet ? 0 : $urandom_range(0, 7);
			if (results_seen == 12)
				k = 120;
			if (k > 0) begin
				res_bus.ready <= 1'b0;
				repeat (k) @(negedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid) @(posedge clk);
			results_seen++;
		end
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
